// ===== hw/rtl/alt_pkg.sv =====
package alt_pkg;

  localparam int unsigned MaxDegreeDefault = 9;
  localparam int unsigned DegW = 4;
  localparam int unsigned ValW = 64;
  localparam int unsigned OpW = 32;
  localparam logic signed [ValW-1:0] OneQ29 = 64'sd536870912;
  localparam logic signed [ValW-1:0] SatMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] SatMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_READ,
    ST_MULQ,
    ST_MULQ2,
    ST_COMB,
    ST_DIV,
    ST_EMIT,
    ST_ROLL
  } alt_state_t;

  // saturate a magnitude with sign into 64-bit signed
  function automatic logic signed [ValW-1:0] from_mag(input logic neg,
                                                      input logic [ValW:0] mag);
    logic signed [ValW-1:0] r;
    if (!neg) begin
      r = (mag > {2'b00, {(ValW-1){1'b1}}}) ? SatMax : mag[ValW-1:0];
    end else begin
      r = (mag >= {2'b01, {(ValW-1){1'b0}}}) ? SatMin : -mag[ValW-1:0];
    end
    return r;
  endfunction

  function automatic logic [ValW-1:0] mag_of(input logic signed [ValW-1:0] v);
    return v[ValW-1] ? (~v + 1'b1) : v;
  endfunction

  // saturating multiply by a small unsigned integer (up to 31)
  function automatic logic signed [ValW-1:0] mul_small(input logic signed [ValW-1:0] v,
                                                       input logic [4:0] k);
    logic [ValW+4:0] p;
    p = mag_of(v) * k;
    return from_mag(v[ValW-1], (|p[ValW+4:ValW]) ? {1'b1, {ValW{1'b0}}} : {1'b0, p[ValW-1:0]});
  endfunction

  function automatic logic signed [ValW-1:0] sat_sub(input logic signed [ValW-1:0] a,
                                                     input logic signed [ValW-1:0] b);
    logic signed [ValW:0] d;
    d = {a[ValW-1], a} - {b[ValW-1], b};
    if (d[ValW] != d[ValW-1]) return d[ValW] ? SatMin : SatMax;
    return d[ValW-1:0];
  endfunction

endpackage

// ===== hw/rtl/alt_if.sv =====
interface alt_in_if import alt_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [OpW-1:0] x_value;
  logic signed [OpW-1:0] sqrt_one_minus_x_sq;
  modport source (output valid, x_value, sqrt_one_minus_x_sq, input ready);
  modport sink (input valid, x_value, sqrt_one_minus_x_sq, output ready);
endinterface

interface alt_out_if import alt_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ValW-1:0] term_value;
  logic [DegW-1:0] degree_index;
  logic [DegW-1:0] order_index;
  logic last_term;
  modport source (output valid, term_value, degree_index, order_index, last_term,
                  input ready);
  modport sink (input valid, term_value, degree_index, order_index, last_term,
                output ready);
endinterface

// ===== hw/rtl/alt_ram.sv =====
module alt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/alt_div.sv =====
// signed division by a small unsigned divisor, truncating toward zero,
// one quotient bit per cycle
module alt_div import alt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [ValW-1:0] dividend,
  input  logic [DegW-1:0]        divisor,
  output logic                   done,
  output logic signed [ValW-1:0] quotient
);
  localparam int unsigned CntW = $clog2(ValW);

  logic [ValW-1:0] q;
  logic [DegW:0] rem;
  logic [DegW-1:0] dv;
  logic neg;
  logic busy;
  logic [CntW-1:0] cnt;
  logic [DegW+1:0] trial;

  assign trial = {rem, q[ValW-1]} - {2'b00, dv};
  assign quotient = neg ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        q <= mag_of(dividend);
        neg <= dividend[ValW-1];
        dv <= divisor;
        rem <= '0;
      end else if (busy) begin
        if (!trial[DegW+1]) begin
          rem <= trial[DegW:0];
          q <= {q[ValW-2:0], 1'b1};
        end else begin
          rem <= {rem[DegW-1:0], q[ValW-1]};
          q <= {q[ValW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(ValW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/associated_legendre_triangle.sv =====
// associated legendre triangle generator
// in channel: one item carries x and sqrt(1-x^2), both signed q1.30
// out channel: one item per term P_n^m, n = 0..max_degree, m = 0..n, in row
// order, signed q34.29 saturated, with degree, order and a last-term flag
// cfg: cfg_we / cfg_data write max_degree (values above MAX_DEGREE clamp)
// rows n-1 and n-2 live in two small synchronous rams; each term reads both,
// runs the q30 product in two 32x32 halves, combines, and (for m < n-1)
// divides by (n-m) in a bit-serial divider; the first term P_0^0 is loaded
// into the output register in the FIRST state after the item is taken; each
// later term passes READ, MULQ, MULQ2, COMB, DIV (only when m < n-1) and
// EMIT, and every row ends with a copy pass that reads and then writes each
// entry; a full degree-9 triangle has 55 terms
// the block takes one item at a time; in.ready is high only while idle
// results sit in an output register; a stalled receiver holds the sequencer
// reset returns to idle with max_degree = 9; ram contents need no clearing
module associated_legendre_triangle import alt_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MaxDegreeDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [DegW-1:0] cfg_data,
  alt_in_if.sink          in,
  alt_out_if.source       out
);
  localparam int unsigned Depth = MAX_DEGREE + 1;
  localparam int unsigned AW = $clog2(Depth);

  alt_state_t state, state_next;
  logic [DegW-1:0] max_degree, top;
  logic signed [OpW-1:0] xr, sr;
  logic [DegW-1:0] n, j;
  logic diag;                        // second pass on m = n uses s
  logic signed [ValW-1:0] prev_rd, pp_rd, acc, mq;
  logic [ValW-1:0] a_mag;
  logic [OpW-1:0] b_mag;
  logic [ValW-1:0] ph, pl;           // a_hi*b, a_lo*b
  logic pneg;
  logic signed [ValW-1:0] row_buf [Depth];
  logic we_p, we_pp;
  logic [AW-1:0] raddr;
  logic div_start, div_done;
  logic div_go;                      // acc is settled, kick the divider
  logic signed [ValW-1:0] div_q;
  logic [4:0] odd;
  logic cp_phase;
  logic out_load;

  assign top = (max_degree > DegW'(MAX_DEGREE)) ? DegW'(MAX_DEGREE) : max_degree;
  assign odd = {n, 1'b0} - 5'd1;

  alt_ram #(.Width(ValW), .Depth(Depth)) u_prev (
    .clk, .we(we_p), .waddr(j[AW-1:0]), .wdata(row_buf[j[AW-1:0]]),
    .raddr, .rdata(prev_rd));
  alt_ram #(.Width(ValW), .Depth(Depth)) u_pprev (
    .clk, .we(we_pp), .waddr(j[AW-1:0]), .wdata(prev_rd),
    .raddr, .rdata(pp_rd));

  alt_div u_div (.clk, .rst, .start(div_start), .dividend(acc),
                 .divisor(n - j), .done(div_done), .quotient(div_q));

  // roll: copy previous to before-previous and row buffer to previous
  assign raddr = (state == ST_READ) ? ((j == n) ? AW'(n - 1'b1) : j[AW-1:0])
                                    : j[AW-1:0];
  assign we_pp = (state == ST_ROLL) && cp_phase && (j < n);
  assign we_p = (state == ST_ROLL) && cp_phase;
  assign div_start = div_go;

  // output register takes a new term
  assign out_load = ((state == ST_FIRST) || (state == ST_EMIT)) && (!out.valid || out.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in.valid) state_next = ST_FIRST;
      ST_FIRST: if (!out.valid || out.ready) state_next = (top == 0) ? ST_IDLE : ST_ROLL;
      ST_READ:  state_next = ST_MULQ;
      ST_MULQ:  state_next = ST_MULQ2;
      ST_MULQ2: state_next = ST_COMB;
      ST_COMB:  state_next = (j + 1'b1 < n) ? ST_DIV : ST_EMIT;
      ST_DIV:   if (div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out.valid || out.ready) begin
          state_next = (j == n) ? ST_ROLL : ST_READ;
          if (j == n && n == top) state_next = ST_ROLL;
        end
      end
      ST_ROLL: begin
        if (cp_phase && j == n) state_next = (n == top) ? ST_IDLE : ST_READ;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_degree <= DegW'(MaxDegreeDefault);
      out.valid <= 1'b0;
      cp_phase <= 1'b0;
      div_go <= 1'b0;
    end else begin
      state <= state_next;
      div_go <= (state == ST_COMB) && (j + 1'b1 < n);
      if (cfg_we) max_degree <= cfg_data;
      if (out.valid && out.ready && !out_load) out.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in.valid) begin
            xr <= in.x_value;
            sr <= in.sqrt_one_minus_x_sq;
            n <= '0;
            j <= '0;
          end
        end
        ST_FIRST: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.term_value <= OneQ29;
            out.degree_index <= '0;
            out.order_index <= '0;
            out.last_term <= (top == 0);
            row_buf[0] <= OneQ29;
            j <= '0;
            cp_phase <= 1'b0;
          end
        end
        ST_READ: diag <= (j == n);
        ST_MULQ: begin
          a_mag <= mag_of(prev_rd);
          b_mag <= diag ? (sr[OpW-1] ? -sr : sr) : (xr[OpW-1] ? -xr : xr);
          pneg <= prev_rd[ValW-1] ^ (diag ? sr[OpW-1] : xr[OpW-1]);
        end
        ST_MULQ2: begin
          ph <= a_mag[ValW-1:OpW] * b_mag;
          pl <= a_mag[OpW-1:0] * b_mag;
        end
        ST_COMB: begin
          if (j + 1'b1 < n) begin
            acc <= sat_sub(mul_small(mq, odd), mul_small(pp_rd, 5'(n + j - 1'b1)));
          end else if (diag) begin
            acc <= (mul_small(mq, odd) == SatMin) ? SatMax : -mul_small(mq, odd);
          end else begin
            acc <= mul_small(mq, odd);
          end
        end
        ST_EMIT: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.term_value <= (j + 1'b1 < n) ? div_q : acc;
            out.degree_index <= n;
            out.order_index <= j;
            out.last_term <= (n == top) && (j == n);
            row_buf[j[AW-1:0]] <= (j + 1'b1 < n) ? div_q : acc;
            if (j == n) begin
              j <= '0;
              cp_phase <= 1'b0;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        ST_ROLL: begin
          // phase 0 reads prev[j]; phase 1 writes prev[j], and pp[j] when j < n
          cp_phase <= ~cp_phase;
          if (cp_phase) begin
            if (j == n) begin
              n <= n + 1'b1;
              j <= '0;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // q30 product from the two registered halves, truncated, saturated
  always_comb begin
    logic [ValW+1:0] sum;
    sum = {ph, 2'b00} + {{(ValW-32){1'b0}}, pl[ValW-1:30]};
    if (|ph[ValW-1:ValW-2] || sum[ValW+1:ValW] != 2'b00) begin
      mq = from_mag(pneg, {1'b1, {ValW{1'b0}}});
    end else begin
      mq = from_mag(pneg, sum[ValW:0]);
    end
  end

endmodule

// ===== hw/rtl/alt_checker.sv =====
module alt_checker import alt_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [DegW-1:0] out_deg,
  input logic [DegW-1:0] out_ord,
  input logic            out_last
);
  a_ord_le_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ord <= out_deg) else $error("order above degree");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_deg))
    else $error("stalled item changed");
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_ord == out_deg) else $error("last not on diagonal");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("took second item");
endmodule

bind associated_legendre_triangle alt_checker u_alt_checker (
  .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .out_deg(out.degree_index), .out_ord(out.order_index),
  .out_last(out.last_term));
